// ===== rtl/core/pfdm_pkg.sv =====
// Shared types, constants and register map of the person-follow drive mapper.
package pfdm_pkg;

	// Feet-row breakpoints of the piecewise score curve
	localparam int unsigned FEET_ROW_STOP = 160;
	localparam int unsigned FEET_ROW_SLOW = 145;
	localparam int unsigned FEET_ROW_FAR  = 80;

	localparam int unsigned FRAME_MIDDLE_COLUMN = 96;
	localparam int unsigned SCORE_MIDPOINT      = 32768;
	localparam int unsigned SCORE_POINT_30      = 19661;
	localparam int unsigned SCORE_POINT_25      = 16384;

	// A segment with empty or reversed bounds is skipped
	localparam bit SEG_NEAR_ON = FEET_ROW_STOP > FEET_ROW_SLOW;
	localparam bit SEG_MID_ON  = FEET_ROW_SLOW > FEET_ROW_FAR;

	localparam int unsigned SPAN_NEAR = SEG_NEAR_ON ? FEET_ROW_STOP - FEET_ROW_SLOW : 1;
	localparam int unsigned SPAN_MID  = SEG_MID_ON ? FEET_ROW_SLOW - FEET_ROW_FAR : 1;

	// floor((2^32-1)/span): estimate never overshoots, one correction step follows
	localparam logic [31:0] RECIP_NEAR = 32'(64'hFFFF_FFFF / 64'(SPAN_NEAR));
	localparam logic [31:0] RECIP_MID  = 32'(64'hFFFF_FFFF / 64'(SPAN_MID));

	// Throttle divider: quotient bits and bits resolved per stage
	localparam int DIV_QBITS  = 15;
	localparam int DIV_DW     = 16;
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = DIV_QBITS / DIV_STEP;

	// Register map (word index)
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_PWM_NEUTRAL      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCORE_HARD_STOP  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SCORE_STEER_LOCK = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCORE_DEADBAND   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_THR_OFFSET   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TURN_GAIN        = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_COL_DEAD_ZONE    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_MAX_STEER_OFFSET = 3'd7;

	localparam logic [15:0] RST_PWM_NEUTRAL      = 16'd1500;
	localparam logic [15:0] RST_SCORE_HARD_STOP  = 16'd58982;
	localparam logic [15:0] RST_SCORE_STEER_LOCK = 16'd45875;
	localparam logic [14:0] RST_SCORE_DEADBAND   = 15'd2621;
	localparam logic [14:0] RST_MAX_THR_OFFSET   = 15'd200;
	localparam logic [15:0] RST_TURN_GAIN        = 16'd512;
	localparam logic [7:0]  RST_COL_DEAD_ZONE    = 8'd8;
	localparam logic [14:0] RST_MAX_STEER_OFFSET = 15'd300;

	typedef enum logic [1:0] {
		SEG_STOP,
		SEG_NEAR,
		SEG_MID,
		SEG_FAR
	} seg_t;

	typedef struct packed {
		logic        person_seen;
		logic [7:0]  centre_column;
		logic [7:0]  feet_row;
		logic [15:0] distance_score;
	} in_item_t;

	typedef struct packed {
		logic [15:0] throttle_pwm;
		logic [15:0] steering_pwm;
	} result_t;

	typedef struct packed {
		logic [15:0] idle_pwm;
		logic [15:0] stop_score;
		logic [15:0] lock_score;
		logic [14:0] band_half;
		logic [14:0] thr_limit;
		logic [15:0] turn_gain;
		logic [7:0]  column_dead_zone;
		logic [14:0] steer_limit;
	} cfg_t;

	// Front end to throttle section
	typedef struct packed {
		logic        seen;
		logic [15:0] score;
		logic [15:0] steer;
	} score_item_t;

	// Travels beside the divider
	typedef struct packed {
		logic        neutral;
		logic        fwd;
		logic        sat;
		logic [15:0] steer;
	} thr_side_t;

endpackage

// ===== rtl/core/person_follow_drive_mapper_unit.sv =====
// Top level of the person-follow drive mapper: report in, throttle and steering PWM out.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------------------------
//  item in  | start, busy (busy held low)    | item   : person_seen, centre_column,
//           |                                |          feet_row, distance_score
//  item out | done, one-cycle strobe         | result : throttle_pwm, steering_pwm
//  config   | psel, penable, pwrite, pready  | paddr (word index in [4:2]), pwdata, prdata
//
// One item is taken every cycle; each result passes through 5 score stages,
// 2 throttle preparation stages, 5 divider stages of 3 quotient bits each, and
// the output register. The restoring divider for the throttle scaling sets the
// depth.
// Reset clears every valid bit and restores the register defaults; there is no
// clearing pass. The receiver cannot stall, so nothing in the pipeline waits:
// a result is shown for exactly one cycle with done high.
module person_follow_drive_mapper_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pfdm_pkg::in_item_t item,
	output logic               done,
	output pfdm_pkg::result_t  result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import pfdm_pkg::*;

	cfg_t                 cfg;
	logic                 in_valid;
	logic                 sc_valid;
	score_item_t          sc_item;
	logic                 dv_valid;
	logic [DIV_QBITS-1:0] dv_quo;
	thr_side_t            dv_side;
	logic [DIV_QBITS-1:0] thr_off;
	logic [15:0]          thr_pwm;
	logic                 done_q;
	result_t              result_q;

	// Fully pipelined with no back-pressure: always ready
	assign busy     = 1'b0;
	assign pready   = 1'b1;
	assign in_valid = start & ~busy;

	pfdm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Score from distance or feet row; steering candidate alongside
	pfdm_score u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.item      (item),
		.cfg       (cfg),
		.out_valid (sc_valid),
		.out_item  (sc_item)
	);

	// Deadband, hard stop, steer lock and the scaled offset
	pfdm_throttle u_throttle (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sc_valid),
		.in_item   (sc_item),
		.cfg       (cfg),
		.out_valid (dv_valid),
		.quotient  (dv_quo),
		.out_side  (dv_side)
	);

	// Take the clamp when the excess reached the span, else the quotient;
	// add forward, subtract for reverse, wrap to 16 bits
	always_comb begin
		thr_off = dv_side.sat ? cfg.thr_limit : dv_quo;
		if (dv_side.neutral) begin
			thr_pwm = cfg.idle_pwm;
		end else if (dv_side.fwd) begin
			thr_pwm = cfg.idle_pwm + 16'(thr_off);
		end else begin
			thr_pwm = cfg.idle_pwm - 16'(thr_off);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	// Hold the result for its one strobe cycle
	always_ff @(posedge clk) begin
		result_q.throttle_pwm <= thr_pwm;
		result_q.steering_pwm <= dv_side.steer;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/pfdm_cfg_regs.sv =====
// APB configuration register file of the drive mapper.
module pfdm_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output pfdm_pkg::cfg_t      cfg
);
	import pfdm_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[4:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_pwm         <= RST_PWM_NEUTRAL;
			cfg_q.stop_score       <= RST_SCORE_HARD_STOP;
			cfg_q.lock_score       <= RST_SCORE_STEER_LOCK;
			cfg_q.band_half        <= RST_SCORE_DEADBAND;
			cfg_q.thr_limit        <= RST_MAX_THR_OFFSET;
			cfg_q.turn_gain        <= RST_TURN_GAIN;
			cfg_q.column_dead_zone <= RST_COL_DEAD_ZONE;
			cfg_q.steer_limit      <= RST_MAX_STEER_OFFSET;
		end else if (wr_en) begin
			case (idx)
				REG_PWM_NEUTRAL:      cfg_q.idle_pwm         <= pwdata[15:0];
				REG_SCORE_HARD_STOP:  cfg_q.stop_score       <= pwdata[15:0];
				REG_SCORE_STEER_LOCK: cfg_q.lock_score       <= pwdata[15:0];
				REG_SCORE_DEADBAND:   cfg_q.band_half        <= pwdata[14:0];
				REG_MAX_THR_OFFSET:   cfg_q.thr_limit        <= pwdata[14:0];
				REG_TURN_GAIN:        cfg_q.turn_gain        <= pwdata[15:0];
				REG_COL_DEAD_ZONE:    cfg_q.column_dead_zone <= pwdata[7:0];
				REG_MAX_STEER_OFFSET: cfg_q.steer_limit      <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PWM_NEUTRAL:      prdata = {16'd0, cfg_q.idle_pwm};
			REG_SCORE_HARD_STOP:  prdata = {16'd0, cfg_q.stop_score};
			REG_SCORE_STEER_LOCK: prdata = {16'd0, cfg_q.lock_score};
			REG_SCORE_DEADBAND:   prdata = {17'd0, cfg_q.band_half};
			REG_MAX_THR_OFFSET:   prdata = {17'd0, cfg_q.thr_limit};
			REG_TURN_GAIN:        prdata = {16'd0, cfg_q.turn_gain};
			REG_COL_DEAD_ZONE:    prdata = {24'd0, cfg_q.column_dead_zone};
			REG_MAX_STEER_OFFSET: prdata = {17'd0, cfg_q.steer_limit};
			default:              prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/pfdm_score.sv =====
// Front pipeline: closeness score from distance or feet row, and steering candidate.
module pfdm_score (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  pfdm_pkg::in_item_t    item,
	input  pfdm_pkg::cfg_t        cfg,
	output logic                  out_valid,
	output pfdm_pkg::score_item_t out_item
);
	import pfdm_pkg::*;

	// Stage 1 combinational
	seg_t        seg;
	logic [15:0] seg_a;
	logic [15:0] seg_b;
	logic [7:0]  seg_pos;
	logic        seg_lo;
	logic [16:0] diff;
	logic [16:0] diff_neg;
	logic [8:0]  ocol;
	logic [8:0]  ocol_neg;

	// Stage registers
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        seen_s1, seen_s2, seen_s3, seen_s4;
	logic [15:0] a_s1, a_s2, a_s3, a_s4;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic        lo_s1, lo_s2, lo_s3;
	logic [15:0] dmag_s1;
	logic [7:0]  pos_s1;
	logic        odead_s1, odead_s2;
	logic        oneg_s1, oneg_s2;
	logic [7:0]  omag_s1;
	logic [23:0] nmag_s2, nmag_s3;
	logic [23:0] oprod_s2;
	logic [15:0] q0_s3;
	logic [15:0] steer_s3, steer_s4;
	logic [15:0] q_s4;
	score_item_t item_s5;

	// Stage 3 and 4 combinational
	logic [55:0] recip_prod;
	logic [31:0] recip_sel;
	logic [15:0] turn_t;
	logic [15:0] turn_cl;
	logic [7:0]  span_sel;
	logic [23:0] qd;
	logic [23:0] rem;

	// Pick the segment; a known distance or a flat segment gives zero slope
	always_comb begin
		if (item.feet_row >= 8'(FEET_ROW_STOP)) begin
			seg = SEG_STOP;
		end else if (SEG_NEAR_ON && item.feet_row >= 8'(FEET_ROW_SLOW)) begin
			seg = SEG_NEAR;
		end else if (SEG_MID_ON && item.feet_row >= 8'(FEET_ROW_FAR)) begin
			seg = SEG_MID;
		end else begin
			seg = SEG_FAR;
		end
		seg_pos = '0;
		seg_lo  = 1'b0;
		case (seg)
			SEG_STOP: begin
				seg_a = cfg.stop_score;
				seg_b = cfg.stop_score;
			end
			SEG_NEAR: begin
				seg_a   = cfg.lock_score;
				seg_b   = cfg.stop_score;
				seg_pos = item.feet_row - 8'(FEET_ROW_SLOW);
			end
			SEG_MID: begin
				seg_a   = 16'(SCORE_POINT_30);
				seg_b   = cfg.lock_score;
				seg_pos = item.feet_row - 8'(FEET_ROW_FAR);
				seg_lo  = 1'b1;
			end
			default: begin
				seg_a = 16'(SCORE_POINT_25);
				seg_b = 16'(SCORE_POINT_25);
			end
		endcase
		if (item.distance_score != '0) begin
			seg_a   = item.distance_score;
			seg_b   = item.distance_score;
			seg_pos = '0;
		end
		diff     = {1'b0, seg_b} - {1'b0, seg_a};
		diff_neg = -diff;
		ocol     = {1'b0, item.centre_column} - 9'(FRAME_MIDDLE_COLUMN);
		ocol_neg = -ocol;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: slope magnitude, position, column offset
	always_ff @(posedge clk) begin
		seen_s1  <= item.person_seen;
		a_s1     <= seg_a;
		neg_s1   <= diff[16];
		dmag_s1  <= diff[16] ? diff_neg[15:0] : diff[15:0];
		pos_s1   <= seg_pos;
		lo_s1    <= seg_lo;
		oneg_s1  <= ocol[8];
		omag_s1  <= ocol[8] ? ocol_neg[7:0] : ocol[7:0];
		odead_s1 <= (ocol[8] ? ocol_neg[7:0] : ocol[7:0]) <= cfg.column_dead_zone;
	end

	// Stage 2: products
	always_ff @(posedge clk) begin
		seen_s2  <= seen_s1;
		a_s2     <= a_s1;
		neg_s2   <= neg_s1;
		lo_s2    <= lo_s1;
		nmag_s2  <= 24'(dmag_s1) * 24'(pos_s1);
		odead_s2 <= odead_s1;
		oneg_s2  <= oneg_s1;
		oprod_s2 <= 24'(omag_s1) * 24'(cfg.turn_gain);
	end

	// Stage 3: reciprocal estimate of the quotient, steering clamp
	always_comb begin
		recip_sel  = lo_s2 ? RECIP_MID : RECIP_NEAR;
		recip_prod = 56'(nmag_s2) * 56'(recip_sel);
		turn_t     = oprod_s2[23:8];
		turn_cl    = (turn_t > {1'b0, cfg.steer_limit}) ?
			{1'b0, cfg.steer_limit} : turn_t;
	end

	always_ff @(posedge clk) begin
		seen_s3 <= seen_s2;
		a_s3    <= a_s2;
		neg_s3  <= neg_s2;
		lo_s3   <= lo_s2;
		nmag_s3 <= nmag_s2;
		q0_s3   <= recip_prod[47:32];
		if (odead_s2) begin
			steer_s3 <= cfg.idle_pwm;
		end else if (oneg_s2) begin
			steer_s3 <= cfg.idle_pwm - turn_cl;
		end else begin
			steer_s3 <= cfg.idle_pwm + turn_cl;
		end
	end

	// Stage 4: correct the estimate by at most one
	always_comb begin
		span_sel = lo_s3 ? 8'(SPAN_MID) : 8'(SPAN_NEAR);
		qd       = 24'(q0_s3) * 24'(span_sel);
		rem      = nmag_s3 - qd;
	end

	always_ff @(posedge clk) begin
		seen_s4  <= seen_s3;
		a_s4     <= a_s3;
		neg_s4   <= neg_s3;
		steer_s4 <= steer_s3;
		q_s4     <= q0_s3 + 16'(rem >= 24'(span_sel));
	end

	// Stage 5: score, truncated toward zero on either slope
	always_ff @(posedge clk) begin
		item_s5.seen  <= seen_s4;
		item_s5.score <= neg_s4 ? a_s4 - q_s4 : a_s4 + q_s4;
		item_s5.steer <= steer_s4;
	end

	assign out_valid = v_s5;
	assign out_item  = item_s5;

endmodule

// ===== rtl/core/pfdm_div.sv =====
// Pipelined restoring divider for the throttle offset, three quotient bits per stage.
module pfdm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [pfdm_pkg::DIV_QBITS+pfdm_pkg::DIV_DW-1:0] dividend,
	input  logic [pfdm_pkg::DIV_DW-1:0]       divisor,
	input  pfdm_pkg::thr_side_t               in_side,
	output logic                              out_valid,
	output logic [pfdm_pkg::DIV_QBITS-1:0]    quotient,
	output pfdm_pkg::thr_side_t               out_side
);
	import pfdm_pkg::*;

	logic [DIV_STAGES-1:0] v_sx;
	logic [DIV_DW-1:0]     rem_sx  [DIV_STAGES];
	logic [DIV_QBITS-1:0]  low_sx  [DIV_STAGES];
	logic [DIV_QBITS-1:0]  quo_sx  [DIV_STAGES];
	thr_side_t             side_sx [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic                 v_in;
		logic [DIV_DW-1:0]    rem_in;
		logic [DIV_QBITS-1:0] low_in;
		logic [DIV_QBITS-1:0] quo_in;
		thr_side_t            side_in;
		logic [DIV_DW-1:0]    rem_nx;
		logic [DIV_QBITS-1:0] low_nx;
		logic [DIV_QBITS-1:0] quo_nx;
		logic [DIV_DW:0]      trial;

		if (g == 0) begin : g_head
			assign v_in    = in_valid;
			assign rem_in  = dividend[DIV_QBITS+DIV_DW-1:DIV_QBITS];
			assign low_in  = dividend[DIV_QBITS-1:0];
			assign quo_in  = '0;
			assign side_in = in_side;
		end else begin : g_body
			assign v_in    = v_sx[g-1];
			assign rem_in  = rem_sx[g-1];
			assign low_in  = low_sx[g-1];
			assign quo_in  = quo_sx[g-1];
			assign side_in = side_sx[g-1];
		end

		// Shift in DIV_STEP dividend bits one at a time, subtract where each fits
		always_comb begin
			rem_nx = rem_in;
			low_nx = low_in;
			quo_nx = quo_in;
			trial  = '0;
			for (int j = 0; j < DIV_STEP; j++) begin
				trial  = {rem_nx, low_nx[DIV_QBITS-1]};
				low_nx = {low_nx[DIV_QBITS-2:0], 1'b0};
				if (trial >= {1'b0, divisor}) begin
					trial  = trial - {1'b0, divisor};
					quo_nx = {quo_nx[DIV_QBITS-2:0], 1'b1};
				end else begin
					quo_nx = {quo_nx[DIV_QBITS-2:0], 1'b0};
				end
				rem_nx = trial[DIV_DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sx[g] <= 1'b0;
			end else begin
				v_sx[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_sx[g]  <= rem_nx;
			low_sx[g]  <= low_nx;
			quo_sx[g]  <= quo_nx;
			side_sx[g] <= side_in;
		end
	end

	assign out_valid = v_sx[DIV_STAGES-1];
	assign quotient  = quo_sx[DIV_STAGES-1];
	assign out_side  = side_sx[DIV_STAGES-1];

endmodule

// ===== rtl/core/pfdm_throttle.sv =====
// Throttle section: deadband and limits, scaled excess, and the divider.
module pfdm_throttle (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  pfdm_pkg::score_item_t          in_item,
	input  pfdm_pkg::cfg_t                 cfg,
	output logic                           out_valid,
	output logic [pfdm_pkg::DIV_QBITS-1:0] quotient,
	output pfdm_pkg::thr_side_t            out_side
);
	import pfdm_pkg::*;

	logic [16:0]                 c;
	logic [16:0]                 c_neg;
	logic [15:0]                 cmag;
	logic [15:0]                 excess;
	logic [16:0]                 span_w;
	logic [DIV_DW-1:0]           span;
	logic                        hs_hit;
	logic                        lock;
	logic                        dead;
	thr_side_t                   side_nx;

	logic                        v_s1, v_s2;
	thr_side_t                   side_s1, side_s2;
	logic [15:0]                 excess_s1;
	logic [DIV_QBITS+DIV_DW-1:0] prod_s2;

	// Span never drops below one since the deadband is at most 32767
	assign span_w = 17'(SCORE_MIDPOINT) - {2'b00, cfg.band_half};
	assign span   = span_w[DIV_DW-1:0];

	always_comb begin
		hs_hit = in_item.score >= cfg.stop_score;
		lock   = in_item.score >= cfg.lock_score;
		c      = 17'(SCORE_MIDPOINT) - {1'b0, in_item.score};
		c_neg  = -c;
		cmag   = c[16] ? c_neg[15:0] : c[15:0];
		dead   = cmag <= {1'b0, cfg.band_half};
		excess = cmag - {1'b0, cfg.band_half};
		side_nx.neutral = !in_item.seen || hs_hit || dead;
		side_nx.fwd     = !c[16] && (c != '0);
		// Excess at or past the span clamps the offset to its maximum
		side_nx.sat     = excess >= span;
		side_nx.steer   = (!in_item.seen || lock) ? cfg.idle_pwm : in_item.steer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1   <= side_nx;
		excess_s1 <= excess;
		side_s2   <= side_s1;
		prod_s2   <= (DIV_QBITS + DIV_DW)'(excess_s1) *
			(DIV_QBITS + DIV_DW)'(cfg.thr_limit);
	end

	pfdm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.dividend  (prod_s2),
		.divisor   (span),
		.in_side   (side_s2),
		.out_valid (out_valid),
		.quotient  (quotient),
		.out_side  (out_side)
	);

endmodule
